/* rtl/cfpc_pkg.sv */
// shared types, codes and helpers for the convex face point classifier
package cfpc_pkg;

   localparam int unsigned VERTEX_SLOTS_DEF = 16;
   localparam int unsigned COORD_W = 32;
   localparam int unsigned TOL_W = 17;
   localparam int unsigned PTOL_W = 32;

   // request commands
   localparam logic [2:0] CMD_NORMAL = 3'd0;
   localparam logic [2:0] CMD_VERTEX = 3'd1;
   localparam logic [2:0] CMD_BOX_LO = 3'd2;
   localparam logic [2:0] CMD_BOX_HI = 3'd3;
   localparam logic [2:0] CMD_QUERY  = 3'd4;

   // register indexes
   localparam logic [1:0] REG_COORD_TOL = 2'd0;
   localparam logic [1:0] REG_BOX_TOL   = 2'd1;
   localparam logic [1:0] REG_PROD_TOL  = 2'd2;

   // projection planes
   localparam logic [1:0] PLANE_XY = 2'd0;
   localparam logic [1:0] PLANE_XZ = 2'd1;
   localparam logic [1:0] PLANE_YZ = 2'd2;

   // point classes
   localparam logic [1:0] CLS_OUTSIDE = 2'd0;
   localparam logic [1:0] CLS_INSIDE  = 2'd1;
   localparam logic [1:0] CLS_EDGE    = 2'd2;

   typedef struct packed {
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      logic signed [COORD_W-1:0] z;
   } vertex_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] u;
      logic signed [COORD_W-1:0] v;
   } uv_type;

   // evaluator status seen by the sequencer
   typedef struct packed {
      logic       busy;
      logic       decided;
      logic [1:0] cls;
      logic       crossed;
   } eval_status_type;

   // project a vertex onto the chosen plane
   function automatic uv_type project(input vertex_type p, input logic [1:0] plane);
      uv_type r;
      case (plane)
         PLANE_YZ: begin
            r.u = p.y;
            r.v = p.z;
         end
         PLANE_XZ: begin
            r.u = p.x;
            r.v = p.z;
         end
         default: begin
            r.u = p.x;
            r.v = p.y;
         end
      endcase
      return r;
   endfunction

endpackage

/* rtl/cfpc_vertex_cell.sv */
// one vertex cell of the rotating vertex chain
module cfpc_vertex_cell (
   input  logic                clock,
   input  logic                write_en,
   input  cfpc_pkg::vertex_type write_data,
   input  logic                shift_en,
   input  cfpc_pkg::vertex_type shift_data,
   output cfpc_pkg::vertex_type vertex
);
   import cfpc_pkg::*;

   vertex_type vertex_ff;

   // load a new vertex or take the neighbor's during rotation
   always_ff @(posedge clock) begin
      if (write_en) begin
         vertex_ff <= write_data;
      end else if (shift_en) begin
         vertex_ff <= shift_data;
      end
   end

   assign vertex = vertex_ff;
endmodule

/* rtl/cfpc_edge_eval.sv */
// three stage edge test: edge setup, magnitude products, decision
module cfpc_edge_eval (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic                    edge_valid,
   input  cfpc_pkg::uv_type        point,
   input  cfpc_pkg::uv_type        vert_a,
   input  cfpc_pkg::uv_type        vert_b,
   input  logic [16:0]             coord_tol,
   input  logic [31:0]             prod_tol,
   output cfpc_pkg::eval_status_type status
);
   import cfpc_pkg::*;

   typedef enum logic [2:0] {
      K_SKIP, K_LEVEL_EDGE, K_LEVEL_OUT, K_CROSS, K_PROD
   } kind_type;

   logic signed [34:0] pu, pv, ua, va, ub, vb, tol;
   logic signed [34:0] lu, lv, hu, hv, lo, hi;
   logic signed [34:0] d1, d2, d3, d4;

   // sign extend the coordinates and zero extend the tolerance to a common width
   always_comb begin
      pu = 35'(point.u);
      pv = 35'(point.v);
      ua = 35'(vert_a.u);
      va = 35'(vert_a.v);
      ub = 35'(vert_b.u);
      vb = 35'(vert_b.v);
      tol = $signed({18'd0, coord_tol});
   end

   function automatic logic near(input logic signed [34:0] a, input logic signed [34:0] b,
                                 input logic signed [34:0] t);
      logic signed [34:0] d;
      d = a - b;
      if (d < 0) d = -d;
      return d < t;
   endfunction

   kind_type        kind_in;
   kind_type        a_kind_ff, b_kind_ff;
   logic            a_vld_ff, b_vld_ff;
   logic            a_dir_ff, b_dir_ff;
   logic [32:0]     m1a_ff, m1b_ff, m2a_ff, m2b_ff;
   logic [65:0]     p1_ff, p2_ff;

   // stage a: classify the edge against the point
   always_comb begin
      if (vb > va) begin
         lu = ua; lv = va; hu = ub; hv = vb;
      end else begin
         lu = ub; lv = vb; hu = ua; hv = va;
      end
      lo = (ua < ub) ? ua : ub;
      hi = (ua < ub) ? ub : ua;
      d1 = hu - pu;
      if (d1 < 0) d1 = -d1;
      d2 = hv - lv;
      d3 = hu - lu;
      if (d3 < 0) d3 = -d3;
      d4 = hv - pv;
      if (near(va, vb, tol)) begin
         if (near(pv, va, tol) || near(pv, vb, tol)) begin
            kind_in = (pu > lo - tol && pu < hi + tol) ? K_LEVEL_EDGE : K_LEVEL_OUT;
         end else begin
            kind_in = K_SKIP;
         end
      end else if (pv >= hv || pv < lv || (pu > lu && pu > hu)) begin
         kind_in = K_SKIP;
      end else if (pu < lu && pu < hu) begin
         kind_in = K_CROSS;
      end else begin
         kind_in = K_PROD;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
      end else begin
         a_vld_ff <= edge_valid;
      end
      a_kind_ff <= kind_in;
      a_dir_ff <= hu > lu;
      m1a_ff <= d1[32:0];
      m1b_ff <= d2[32:0];
      m2a_ff <= d3[32:0];
      m2b_ff <= d4[32:0];
   end

   // stage b: the two exact products
   always_ff @(posedge clock) begin
      if (reset) begin
         b_vld_ff <= 1'b0;
      end else begin
         b_vld_ff <= a_vld_ff;
      end
      b_kind_ff <= a_kind_ff;
      b_dir_ff <= a_dir_ff;
      p1_ff <= m1a_ff * m1b_ff;
      p2_ff <= m2a_ff * m2b_ff;
   end

   // stage c: in-order decision
   logic        decided_ff, decided_in;
   logic        crossed_ff, crossed_in;
   logic [1:0]  cls_ff, cls_in;
   logic [65:0] diff;
   logic        hit;

   always_comb begin
      diff = (p1_ff > p2_ff) ? p1_ff - p2_ff : p2_ff - p1_ff;
      decided_in = decided_ff;
      crossed_in = crossed_ff;
      cls_in = cls_ff;
      hit = 1'b0;
      if (b_vld_ff && !decided_ff) begin
         case (b_kind_ff)
            K_LEVEL_EDGE: begin
               decided_in = 1'b1;
               cls_in = CLS_EDGE;
            end
            K_LEVEL_OUT: begin
               decided_in = 1'b1;
               cls_in = CLS_OUTSIDE;
            end
            K_CROSS: hit = 1'b1;
            K_PROD: begin
               if (diff < {34'd0, prod_tol}) begin
                  decided_in = 1'b1;
                  cls_in = CLS_EDGE;
               end else begin
                  hit = b_dir_ff ? (p1_ff > p2_ff) : (p2_ff > p1_ff);
               end
            end
            default: hit = 1'b0;
         endcase
         if (hit) begin
            if (crossed_ff) begin
               decided_in = 1'b1;
               cls_in = CLS_OUTSIDE;
            end else begin
               crossed_in = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset || start) begin
         decided_ff <= 1'b0;
         crossed_ff <= 1'b0;
         cls_ff <= CLS_OUTSIDE;
      end else begin
         decided_ff <= decided_in;
         crossed_ff <= crossed_in;
         cls_ff <= cls_in;
      end
   end

   assign status.busy = a_vld_ff | b_vld_ff;
   assign status.decided = decided_ff;
   assign status.cls = cls_ff;
   assign status.crossed = crossed_ff;
endmodule

/* rtl/convex_face_point_classifier_core.sv */
// top level of the convex face point classifier
// A query walks the vertex chain after the box check, unless there are no vertices or the
// box misses, in which case it answers straight after the box check; other commands leave
// the sequencer idle. The vertex chain rotates one vertex per cycle into a shared
// three stage edge tester (setup, 33x33 products, decision), which is then drained.
// Requests are not taken while a query is in flight, and a query whose result
// finds the previous one still stalled waits for it; configuration writes are always
// taken. Vertex storage holds undefined data until written.
module convex_face_point_classifier_core #(
   parameter int unsigned VERTEX_SLOTS = cfpc_pkg::VERTEX_SLOTS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_command,
   input  logic signed [31:0] req_coord_x,
   input  logic signed [31:0] req_coord_y,
   input  logic signed [31:0] req_coord_z,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_class,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_data
);
   import cfpc_pkg::*;

   localparam int unsigned CNT_W = $clog2(VERTEX_SLOTS + 1);

   typedef enum logic [2:0] {S_IDLE, S_BOX, S_RUN, S_DRAIN, S_DONE} state_type;

   state_type       state_ff;
   logic [16:0]     coord_tol_ff, box_tol_ff;
   logic [31:0]     prod_tol_ff;
   logic [CNT_W-1:0] count_ff, step_ff;
   logic [1:0]      plane_ff;
   vertex_type      box_lo_ff, box_hi_ff, point_ff, last_ff;
   uv_type          prev_ff;
   logic [1:0]      cls_ff, rsp_cls_ff;
   logic            rsp_valid_ff;
   vertex_type      req_vertex;
   vertex_type      cell_q [VERTEX_SLOTS];
   eval_status_type status;
   logic            accept, add_vertex, rotate, eval_start, edge_valid;
   logic            inbox;
   logic [31:0]     ax, ay, az;

   assign req_vertex = '{x: req_coord_x, y: req_coord_y, z: req_coord_z};
   assign accept = req_valid && !req_stall;
   assign req_stall = state_ff != S_IDLE;
   assign csr_ready = 1'b1;
   assign add_vertex = accept && req_command == CMD_VERTEX &&
                       count_ff < CNT_W'(VERTEX_SLOTS);
   assign rotate = state_ff == S_RUN;
   assign edge_valid = state_ff == S_RUN;
   assign eval_start = state_ff == S_BOX;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         coord_tol_ff <= 17'd7;
         box_tol_ff <= 17'd7;
         prod_tol_ff <= 32'd429497;
      end else if (csr_valid) begin
         case (csr_index)
            REG_COORD_TOL: coord_tol_ff <= csr_data[16:0];
            REG_BOX_TOL:   box_tol_ff <= csr_data[16:0];
            REG_PROD_TOL:  prod_tol_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // vertex chain: decoded writes, rotation wraps at the fill count
   for (genvar k = 0; k < VERTEX_SLOTS; k++) begin : g_cell
      vertex_type nxt;
      if (k == VERTEX_SLOTS - 1) begin : g_last
         assign nxt = cell_q[0];
      end else begin : g_mid
         assign nxt = (CNT_W'(k + 1) < count_ff) ? cell_q[k + 1] : cell_q[0];
      end
      cfpc_vertex_cell u_cell (
         .clock      (clock),
         .write_en   (add_vertex && count_ff == CNT_W'(k)),
         .write_data (req_vertex),
         .shift_en   (rotate),
         .shift_data (nxt),
         .vertex     (cell_q[k])
      );
   end

   // normal magnitudes for the plane choice
   always_comb begin
      ax = req_coord_x[31] ? 32'(-req_coord_x) : 32'(req_coord_x);
      ay = req_coord_y[31] ? 32'(-req_coord_y) : 32'(req_coord_y);
      az = req_coord_z[31] ? 32'(-req_coord_z) : 32'(req_coord_z);
   end

   // widened box test on the held point
   function automatic logic box_axis(input logic signed [31:0] v, input logic signed [31:0] lo,
                                     input logic signed [31:0] hi, input logic [16:0] t);
      logic signed [33:0] tt;
      tt = $signed({17'd0, t});
      return (34'(v) > 34'(lo) - tt) && (34'(v) < 34'(hi) + tt);
   endfunction

   assign inbox = box_axis(point_ff.x, box_lo_ff.x, box_hi_ff.x, box_tol_ff) &&
                  box_axis(point_ff.y, box_lo_ff.y, box_hi_ff.y, box_tol_ff) &&
                  box_axis(point_ff.z, box_lo_ff.z, box_hi_ff.z, box_tol_ff);

   cfpc_edge_eval u_eval (
      .clock      (clock),
      .reset      (reset),
      .start      (eval_start),
      .edge_valid (edge_valid),
      .point      (project(point_ff, plane_ff)),
      .vert_a     (prev_ff),
      .vert_b     (project(cell_q[0], plane_ff)),
      .coord_tol  (coord_tol_ff),
      .prod_tol   (prod_tol_ff),
      .status     (status)
   );

   // sequencer, face state and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         plane_ff <= PLANE_XY;
         box_lo_ff <= '0;
         box_hi_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && !rsp_stall && state_ff != S_DONE) rsp_valid_ff <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  case (req_command)
                     CMD_NORMAL: begin
                        count_ff <= '0;
                        if (ax > ay) plane_ff <= (ax > az) ? PLANE_YZ : PLANE_XY;
                        else plane_ff <= (ay > az) ? PLANE_XZ : PLANE_XY;
                     end
                     CMD_VERTEX: if (add_vertex) count_ff <= count_ff + 1'b1;
                     CMD_BOX_LO: box_lo_ff <= req_vertex;
                     CMD_BOX_HI: box_hi_ff <= req_vertex;
                     CMD_QUERY: state_ff <= S_BOX;
                     default: ;
                  endcase
               end
            end
            S_BOX: begin
               if (!inbox || count_ff == '0) begin
                  cls_ff <= CLS_OUTSIDE;
                  state_ff <= S_DONE;
               end else begin
                  state_ff <= S_RUN;
               end
            end
            S_RUN: if (step_ff == count_ff - 1'b1) state_ff <= S_DRAIN;
            S_DRAIN: begin
               if (!status.busy) begin
                  cls_ff <= status.decided ? status.cls :
                            (status.crossed ? CLS_INSIDE : CLS_OUTSIDE);
                  state_ff <= S_DONE;
               end
            end
            S_DONE: begin
               if (!rsp_valid_ff || !rsp_stall) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_cls_ff <= cls_ff;
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   // payload: held point, last vertex, walk position
   always_ff @(posedge clock) begin
      if (accept) point_ff <= req_vertex;
      if (add_vertex) last_ff <= req_vertex;
      if (state_ff == S_BOX) begin
         step_ff <= '0;
         prev_ff <= project(last_ff, plane_ff);
      end else if (state_ff == S_RUN) begin
         step_ff <= step_ff + 1'b1;
         prev_ff <= project(cell_q[0], plane_ff);
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_class = rsp_cls_ff;

`ifndef SYNTH
   a_count_max: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(VERTEX_SLOTS)) else $error("vertex count overflow");
   a_run_nonempty: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_RUN |-> count_ff != '0) else $error("walk over empty face");
   a_cls_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_cls_ff != 2'd3) else $error("illegal class");
   a_drain_idle: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_IDLE |-> !status.busy) else $error("tester busy while idle");
`endif
endmodule

/* test/convex_face_point_classifier_core_test.sv */
// self-checking testbench for the convex face point classifier core
`timescale 1ns / 100ps

module convex_face_point_classifier_core_test;
   import cfpc_pkg::*;

   typedef struct {
      logic [2:0]         command;
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic signed [31:0] z;
   } face_request_type;

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_stall;
   logic [2:0]        req_command;
   logic signed [31:0] req_coord_x;
   logic signed [31:0] req_coord_y;
   logic signed [31:0] req_coord_z;
   logic              rsp_valid;
   logic              rsp_stall;
   logic [1:0]        rsp_class;
   logic              csr_valid;
   logic              csr_ready;
   logic [1:0]        csr_index;
   logic [31:0]       csr_data;

   convex_face_point_classifier_core dut (.*);

   // predictor state
   logic [16:0] coord_tol;
   logic [16:0] box_tol;
   logic [31:0] prod_tol;
   logic signed [31:0] face_x [16];
   logic signed [31:0] face_y [16];
   logic signed [31:0] face_z [16];
   int unsigned face_count;
   logic [1:0]  face_proj;
   logic signed [31:0] box_lo [3];
   logic signed [31:0] box_hi [3];

   face_request_type pending_requests[$];
   logic [1:0]       expected_classes[$];
   int unsigned      mismatch_count;
   int unsigned      query_count;
   int unsigned      class_seen [3];
   longint unsigned  cycle_count;
   int               burst_left;
   int               gap_left;
   logic             stall_mode;
   bit               stimulus_done;

   // clock
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > 64'd400000) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   function automatic bit near_equal(longint a, longint b);
      longint d;
      d = a - b;
      if (d < 0) d = -d;
      return d < longint'(coord_tol);
   endfunction

   function automatic longint unsigned abs_mag(longint d);
      return d < 0 ? longint'(-d) : d;
   endfunction

   // ray crossing over the projected face, closing edge first
   function automatic logic [1:0] crossing_class(longint pu, longint pv, int unsigned plane);
      longint us [16];
      longint vs [16];
      longint ua, va, ub, vb, lu, lv, hu, hv, lo, hi;
      longint unsigned p1, p2, diff;
      int unsigned a;
      bit crossed, hit;
      crossed = 0;
      for (int i = 0; i < 16; i++) begin
         us[i] = (plane == PLANE_YZ) ? face_y[i] : face_x[i];
         vs[i] = (plane == PLANE_XY) ? face_y[i] : face_z[i];
      end
      if (face_count == 0) return CLS_OUTSIDE;
      for (int unsigned k = 0; k < face_count; k++) begin
         a = (k == 0) ? face_count - 1 : k - 1;
         ua = us[a]; va = vs[a]; ub = us[k]; vb = vs[k];
         hit = 0;
         if (near_equal(va, vb)) begin
            if (near_equal(pv, va) || near_equal(pv, vb)) begin
               lo = ua < ub ? ua : ub;
               hi = ua < ub ? ub : ua;
               if (pu > lo - longint'(coord_tol) && pu < hi + longint'(coord_tol))
                  return CLS_EDGE;
               return CLS_OUTSIDE;
            end
            continue;
         end
         if (vb > va) begin
            lu = ua; lv = va; hu = ub; hv = vb;
         end else begin
            lu = ub; lv = vb; hu = ua; hv = va;
         end
         if (pv >= hv || pv < lv) continue;
         if (pu > lu && pu > hu) continue;
         if (pu < lu && pu < hu) begin
            hit = 1;
         end else begin
            p1 = abs_mag(hu - pu) * longint'(hv - lv);
            p2 = abs_mag(hu - lu) * longint'(hv - pv);
            diff = p1 > p2 ? p1 - p2 : p2 - p1;
            if (diff < longint'(prod_tol)) return CLS_EDGE;
            hit = (hu > lu) ? (p1 > p2) : (p2 > p1);
         end
         if (hit) begin
            if (crossed) return CLS_OUTSIDE;
            crossed = 1;
         end
      end
      return crossed ? CLS_INSIDE : CLS_OUTSIDE;
   endfunction

   // apply one accepted request to the predictor
   function automatic void predict_face_request(face_request_type r);
      longint ax, ay, az;
      longint p [3];
      bit inside_box;
      p[0] = r.x; p[1] = r.y; p[2] = r.z;
      case (r.command)
         CMD_NORMAL: begin
            ax = abs_mag(p[0]); ay = abs_mag(p[1]); az = abs_mag(p[2]);
            if (ax > ay) face_proj = (ax > az) ? PLANE_YZ : PLANE_XY;
            else face_proj = (ay > az) ? PLANE_XZ : PLANE_XY;
            face_count = 0;
         end
         CMD_VERTEX: begin
            if (face_count < 16) begin
               face_x[face_count] = r.x;
               face_y[face_count] = r.y;
               face_z[face_count] = r.z;
               face_count++;
            end
         end
         CMD_BOX_LO: begin
            box_lo[0] = r.x; box_lo[1] = r.y; box_lo[2] = r.z;
         end
         CMD_BOX_HI: begin
            box_hi[0] = r.x; box_hi[1] = r.y; box_hi[2] = r.z;
         end
         CMD_QUERY: begin
            inside_box = 1;
            for (int i = 0; i < 3; i++) begin
               if (!(p[i] > longint'(box_lo[i]) - longint'(box_tol))) inside_box = 0;
               if (!(p[i] < longint'(box_hi[i]) + longint'(box_tol))) inside_box = 0;
            end
            if (!inside_box) expected_classes.push_back(CLS_OUTSIDE);
            else if (face_proj == PLANE_YZ)
               expected_classes.push_back(crossing_class(r.y, r.z, PLANE_YZ));
            else if (face_proj == PLANE_XZ)
               expected_classes.push_back(crossing_class(r.x, r.z, PLANE_XZ));
            else
               expected_classes.push_back(crossing_class(r.x, r.y, PLANE_XY));
         end
         default: ;
      endcase
   endfunction

   // request driver: bursts with random gaps
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         burst_left <= 0;
         gap_left <= 0;
      end else if (!req_valid || !req_stall) begin
         if (req_valid) begin
            predict_face_request('{req_command, req_coord_x, req_coord_y, req_coord_z});
            void'(pending_requests.pop_front());
         end
         if (gap_left > 0) begin
            gap_left <= gap_left - 1;
            req_valid <= 1'b0;
         end else if (pending_requests.size() > 0) begin
            face_request_type nxt;
            nxt = pending_requests[0];
            req_valid <= 1'b1;
            req_command <= nxt.command;
            req_coord_x <= nxt.x;
            req_coord_y <= nxt.y;
            req_coord_z <= nxt.z;
            if (burst_left == 0) begin
               burst_left <= $urandom_range(1, 20);
               if ($urandom_range(0, 2) == 0) gap_left <= $urandom_range(1, 6);
            end else begin
               burst_left <= burst_left - 1;
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // result monitor with its own stall pattern
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_mode <= 1'b0;
      end else begin
         if ($urandom_range(0, 63) == 0) stall_mode <= ~stall_mode;
         rsp_stall <= stall_mode ? ($urandom_range(0, 2) != 0) : 1'b0;
         if (rsp_valid && !rsp_stall) begin
            if (expected_classes.size() == 0) begin
               $display("%0t: unexpected result, expected none, actual %0d",
                        $time, rsp_class);
               mismatch_count++;
            end else begin
               logic [1:0] want;
               want = expected_classes.pop_front();
               if (rsp_class !== want) begin
                  $display("%0t: class mismatch, expected %0d, actual %0d",
                           $time, want, rsp_class);
                  mismatch_count++;
               end
               if (want < 3) class_seen[want]++;
               query_count++;
            end
         end
      end
   end

   task automatic queue_request(logic [2:0] c, logic [31:0] x, logic [31:0] y,
                                logic [31:0] z);
      pending_requests.push_back('{c, x, y, z});
   endtask

   task automatic wait_idle();
      while (pending_requests.size() != 0 || req_valid || expected_classes.size() != 0)
         @(posedge clock);
      repeat (30) @(posedge clock);
   endtask

   task automatic write_register(logic [1:0] idx, logic [31:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      @(posedge clock);
      case (idx)
         REG_COORD_TOL: coord_tol = val[16:0];
         REG_BOX_TOL:   box_tol = val[16:0];
         default:       prod_tol = val;
      endcase
   endtask

   function automatic logic [31:0] rand_coord();
      case ($urandom_range(0, 3))
         0: return $urandom();
         1: return $signed($urandom_range(0, 2000)) - 1000;
         default: return ($signed($urandom_range(0, 20)) - 10) <<< 16;
      endcase
   endfunction

   // one face: normal, box, vertices of a rough convex polygon, then queries and sometimes an undefined command
   task automatic queue_random_face(int unsigned nverts, int unsigned nqueries);
      int unsigned plane;
      logic [31:0] cx, cy, r, ang;
      int signed ox, oy;
      logic [31:0] c [3];
      plane = $urandom_range(0, 2);
      queue_request(CMD_NORMAL, plane == 2 ? 32'sd65536 : 32'd1,
                    plane == 1 ? 32'sd65536 : 32'd2, plane == 0 ? 32'sd65536 : 32'd0);
      if ($urandom_range(0, 3) == 0) begin
         queue_request(CMD_BOX_LO, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
         queue_request(CMD_BOX_HI, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
      end else begin
         queue_request(CMD_BOX_LO, -(12 <<< 16), -(12 <<< 16), -(12 <<< 16));
         queue_request(CMD_BOX_HI, 12 <<< 16, 12 <<< 16, 12 <<< 16);
      end
      r = $urandom_range(2, 8) <<< 16;
      for (int i = 0; i < nverts; i++) begin
         // octagon-ish ring, points snapped so edges and vertices get hit
         case ((i * 8) / (nverts == 0 ? 1 : nverts))
            0: begin ox = 2; oy = 0; end
            1: begin ox = 1; oy = 1; end
            2: begin ox = 0; oy = 2; end
            3: begin ox = -1; oy = 1; end
            4: begin ox = -2; oy = 0; end
            5: begin ox = -1; oy = -1; end
            6: begin ox = 0; oy = -2; end
            default: begin ox = 1; oy = -1; end
         endcase
         cx = ox * (r >>> 1);
         cy = oy * (r >>> 1);
         c[0] = plane == 2 ? $urandom_range(0, 100) : cx;
         c[1] = plane == 2 ? cx : (plane == 1 ? $urandom_range(0, 100) : cy);
         c[2] = plane == 0 ? $urandom_range(0, 100) : cy;
         queue_request(CMD_VERTEX, c[0], c[1], c[2]);
      end
      for (int q = 0; q < nqueries; q++)
         queue_request(CMD_QUERY, rand_coord(), rand_coord(), rand_coord());
      if ($urandom_range(0, 7) == 0)
         queue_request(3'($urandom_range(5, 7)), $urandom(), $urandom(), $urandom());
   endtask

   // stimulus
   initial begin
      int unsigned total;
      reset = 1'b1;
      req_valid = 1'b0;
      req_command = CMD_NORMAL;
      req_coord_x = '0;
      req_coord_y = '0;
      req_coord_z = '0;
      rsp_stall = 1'b0;
      csr_valid = 1'b0;
      csr_index = REG_COORD_TOL;
      csr_data = '0;
      cycle_count = 0;
      mismatch_count = 0;
      query_count = 0;
      coord_tol = 7;
      box_tol = 7;
      prod_tol = 429497;
      face_count = 0;
      face_proj = PLANE_XY;
      for (int i = 0; i < 3; i++) begin
         box_lo[i] = '0;
         box_hi[i] = '0;
         class_seen[i] = 0;
      end
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty face, zero box, field extremes, one vertex, full list
      queue_request(CMD_QUERY, 32'd0, 32'd0, 32'd0);
      queue_request(CMD_BOX_LO, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
      queue_request(CMD_BOX_HI, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
      queue_request(CMD_QUERY, 32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff);
      queue_request(CMD_NORMAL, 32'h8000_0000, 32'h7fff_ffff, 32'd0);
      queue_request(CMD_VERTEX, 32'h0001_0000, 32'h7fff_ffff, 32'h0001_0000);
      queue_request(CMD_QUERY, 32'h0001_0000, 32'd5, 32'h0001_0000);
      queue_request(CMD_QUERY, 32'h0005_0000, 32'd5, 32'h0001_0000);
      queue_request(3'd7, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
      queue_request(CMD_NORMAL, 32'd0, 32'd0, 32'h8000_0000);
      for (int i = 0; i < 17; i++)
         queue_request(CMD_VERTEX, (i < 8 ? i : 16 - i) <<< 16,
                       (i < 8 ? 8 - i : i - 8) <<< 16, 32'd0);
      queue_request(CMD_QUERY, 32'h0001_0000, 32'h0002_0000, 32'd0);
      queue_request(CMD_QUERY, 32'h0004_0000, 32'h0004_0000, 32'd0);
      wait_idle();

      // random phases over several register settings, extremes included
      total = 0;
      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0: begin
               write_register(REG_COORD_TOL, 0);
               write_register(REG_BOX_TOL, 0);
               write_register(REG_PROD_TOL, 0);
            end
            1: begin
               write_register(REG_COORD_TOL, 65536);
               write_register(REG_BOX_TOL, 65536);
               write_register(REG_PROD_TOL, 32'hffff_ffff);
            end
            default: begin
               write_register(REG_COORD_TOL, $urandom_range(0, 65536));
               write_register(REG_BOX_TOL, $urandom_range(0, 65536));
               write_register(REG_PROD_TOL, $urandom());
            end
         endcase
         for (int f = 0; f < 6; f++) begin
            int unsigned nv, nq;
            nv = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 18) : $urandom_range(3, 8);
            nq = $urandom_range(8, 20);
            queue_random_face(nv, nq);
            total += nv + nq + 3;
         end
         wait_idle();
      end
      while (total < 1050) begin
         int unsigned nv, nq;
         nv = $urandom_range(3, 8);
         nq = $urandom_range(8, 20);
         queue_random_face(nv, nq);
         total += nv + nq + 3;
         if (pending_requests.size() > 200) wait_idle();
      end
      wait_idle();

      $display("covered %0d queries: outside %0d, inside %0d, on edge %0d",
               query_count, class_seen[0], class_seen[1], class_seen[2]);
      if (mismatch_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
